// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the register block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define VMM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define VMM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/vmmio_pkg.sv =====
// ----------------------------------------------------------------------------
// vmmio_pkg
// Constants shared by the virtio-mmio register block: operation codes,
// register offsets, identity words and parameter defaults.
// ----------------------------------------------------------------------------
package vmmio_pkg;

    localparam int QUEUE_COUNT_DEF  = 2;
    localparam int QUEUE_MAX_DEF    = 256;
    localparam int CONFIG_BYTES_DEF = 8;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RAISE = 2'd2;

    localparam logic [1:0] CFG_DEVICE_PRESENT    = 2'd0;
    localparam logic [1:0] CFG_MAC_ADDRESS       = 2'd1;
    localparam logic [1:0] CFG_CONFIG_GENERATION = 2'd2;

    localparam logic [11:0] OFF_MAGIC        = 12'h000;
    localparam logic [11:0] OFF_VERSION      = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID    = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID    = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT     = 12'h010;
    localparam logic [11:0] OFF_DEV_FEAT_SEL = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT     = 12'h020;
    localparam logic [11:0] OFF_DRV_FEAT_SEL = 12'h024;
    localparam logic [11:0] OFF_PAGE_SIZE    = 12'h028;
    localparam logic [11:0] OFF_QUEUE_SEL    = 12'h030;
    localparam logic [11:0] OFF_QUEUE_MAX    = 12'h034;
    localparam logic [11:0] OFF_QUEUE_NUM    = 12'h038;
    localparam logic [11:0] OFF_QUEUE_READY  = 12'h044;
    localparam logic [11:0] OFF_QUEUE_NOTIFY = 12'h050;
    localparam logic [11:0] OFF_INT_STATUS   = 12'h060;
    localparam logic [11:0] OFF_INT_ACK      = 12'h064;
    localparam logic [11:0] OFF_STATUS       = 12'h070;
    localparam logic [11:0] OFF_DESC_LOW     = 12'h080;
    localparam logic [11:0] OFF_DESC_HIGH    = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LOW    = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HIGH   = 12'h094;
    localparam logic [11:0] OFF_USED_LOW     = 12'h0a0;
    localparam logic [11:0] OFF_USED_HIGH    = 12'h0a4;
    localparam logic [11:0] OFF_CONFIG_GEN   = 12'h0fc;
    localparam logic [11:0] CFG_BASE         = 12'h100;

    localparam logic [31:0] MAGIC_WORD      = 32'h74726976;
    localparam logic [31:0] VERSION_WORD    = 32'd2;
    localparam logic [31:0] NET_DEVICE_ID   = 32'd1;
    localparam logic [31:0] VENDOR_WORD     = 32'h41564d31;
    localparam logic [63:0] FEATURES_ALL    = 64'h0000_0001_0001_8020;
    localparam logic [31:0] PAGE_SIZE_RESET = 32'd4096;

    localparam int CFG_WINDOW_LANES = 8;
    localparam int MAC_BYTES        = 6;
    localparam logic [7:0] LINK_UP_BYTE = 8'd1;

endpackage

// ===== hdl/vmmio_cfg_window.sv =====
// ----------------------------------------------------------------------------
// vmmio_cfg_window
// Read path of the device config window: assembles up to eight bytes of
// MAC address and link status, little-endian, with the range check.
// ----------------------------------------------------------------------------
module vmmio_cfg_window #(
    parameter int CONFIG_BYTES = vmmio_pkg::CONFIG_BYTES_DEF
) (
    input  logic        i_present,
    input  logic [47:0] i_mac,
    input  logic [7:0]  i_rel,
    input  logic [3:0]  i_size,
    output logic [63:0] o_data
);

    localparam int LANES = vmmio_pkg::CFG_WINDOW_LANES;

    logic       w_ok;
    logic [9:0] w_end;

    assign w_end = {2'b00, i_rel} + {6'b000000, i_size};
    assign w_ok  = i_present && (i_size != 4'd0) && (i_size <= 4'(LANES))
                   && (w_end <= 10'(CONFIG_BYTES));

    always_comb begin
        logic [8:0] idx;
        logic [7:0] byte_v;
        o_data = '0;
        for (int k = 0; k < LANES; k++) begin
            idx = {1'b0, i_rel} + 9'(k);
            if (idx < 9'(vmmio_pkg::MAC_BYTES)) begin
                byte_v = i_mac[8*idx[2:0] +: 8];
            end else if (idx == 9'(vmmio_pkg::MAC_BYTES)) begin
                byte_v = vmmio_pkg::LINK_UP_BYTE;
            end else begin
                byte_v = 8'd0;
            end
            if (w_ok && (4'(k) < i_size)) begin
                o_data[8*k +: 8] = byte_v;
            end
        end
    end

endmodule

// ===== hdl/virtio_mmio_register_block.sv =====
// ----------------------------------------------------------------------------
// virtio_mmio_register_block
// Register front end of a virtio-mmio version 2 network device.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one bus access or one
//   interrupt-raise event per transfer: op, offset, access size, write data
//   and raise bits. Output channel (o_out_valid / i_out_stall) returns one
//   result per transfer: read data, queue notify pulse and interrupt line.
//   The result of a transfer is registered and is valid after the edge
//   that takes it. Throughput is one transfer per cycle unless stalled;
//   decode and register update lie between input and result register.
//   When the receiver stalls, the result register holds and the next input
//   is accepted only once the held result has left, so o_in_stall follows
//   a full, stalled result register.
//   Configuration (present flag, MAC, config generation) is written over
//   the plain write port, by the user, while the block is idle (unchecked).
//   Reset (synchronous, active low) clears all device registers to their
//   defaults (page size 4096) and empties the result register. A status
//   write of zero performs the same clear of device state, not config.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module virtio_mmio_register_block #(
    parameter int QUEUE_COUNT  = vmmio_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_MAX    = vmmio_pkg::QUEUE_MAX_DEF,
    parameter int CONFIG_BYTES = vmmio_pkg::CONFIG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [11:0] i_offset,
    input  logic [3:0]  i_access_size,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_raise_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_read_data,
    output logic        o_notify_valid,
    output logic        o_notify_queue,
    output logic        o_irq_line
);

    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int LW = $clog2(QUEUE_MAX + 1);
    localparam logic [LW-1:0] QMAX_V = LW'(QUEUE_MAX);

    logic          r_dev_present;
    logic [47:0]   r_mac;
    logic [31:0]   r_cfg_gen;

    logic [31:0]   r_feat_sel,   n_feat_sel;
    logic [31:0]   r_drv_sel,    n_drv_sel;
    logic [63:0]   r_drv_feat,   n_drv_feat;
    logic [31:0]   r_page_size,  n_page_size;
    logic [31:0]   r_queue_sel,  n_queue_sel;
    logic [LW-1:0] r_qlen  [QUEUE_COUNT];
    logic [LW-1:0] n_qlen  [QUEUE_COUNT];
    logic          r_qrdy  [QUEUE_COUNT];
    logic          n_qrdy  [QUEUE_COUNT];
    logic [63:0]   r_desc  [QUEUE_COUNT];
    logic [63:0]   n_desc  [QUEUE_COUNT];
    logic [63:0]   r_avail [QUEUE_COUNT];
    logic [63:0]   n_avail [QUEUE_COUNT];
    logic [63:0]   r_used  [QUEUE_COUNT];
    logic [63:0]   n_used  [QUEUE_COUNT];
    logic [31:0]   r_int_status, n_int_status;
    logic [31:0]   r_dev_status, n_dev_status;

    logic          r_out_valid;
    logic [63:0]   r_read_data,  n_read_data;
    logic          r_notify_valid, n_notify_valid;
    logic          r_notify_queue, n_notify_queue;
    logic          r_irq_line;

    logic          w_in_acc;
    logic          w_in_window;
    logic [7:0]    w_rel;
    logic [63:0]   w_win_data;
    logic          w_qok;
    logic [QW-1:0] w_q;
    logic          w_reg_access;
    logic [31:0]   w_reg_rd;
    logic [63:0]   w_feats;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_in_window = (i_offset >= vmmio_pkg::CFG_BASE)
                         && ({1'b0, i_offset} < ({1'b0, vmmio_pkg::CFG_BASE}
                                                 + 13'(CONFIG_BYTES)));
    assign w_rel        = 8'(i_offset - vmmio_pkg::CFG_BASE);
    assign w_reg_access = !w_in_window && (i_access_size == 4'd4);
    assign w_qok        = r_queue_sel < 32'(QUEUE_COUNT);
    assign w_q          = w_qok ? r_queue_sel[QW-1:0] : '0;
    assign w_feats      = r_dev_present ? vmmio_pkg::FEATURES_ALL : 64'd0;

    vmmio_cfg_window #(
        .CONFIG_BYTES (CONFIG_BYTES)
    ) u_cfg_window (
        .i_present (r_dev_present),
        .i_mac     (r_mac),
        .i_rel     (w_rel),
        .i_size    (i_access_size),
        .o_data    (w_win_data)
    );

    always_comb begin
        w_reg_rd = 32'd0;
        case (i_offset)
            vmmio_pkg::OFF_MAGIC:      w_reg_rd = vmmio_pkg::MAGIC_WORD;
            vmmio_pkg::OFF_VERSION:    w_reg_rd = vmmio_pkg::VERSION_WORD;
            vmmio_pkg::OFF_DEVICE_ID: begin
                w_reg_rd = r_dev_present ? vmmio_pkg::NET_DEVICE_ID : 32'd0;
            end
            vmmio_pkg::OFF_VENDOR_ID:  w_reg_rd = vmmio_pkg::VENDOR_WORD;
            vmmio_pkg::OFF_DEV_FEAT: begin
                if (r_feat_sel == 32'd0) begin
                    w_reg_rd = w_feats[31:0];
                end else if (r_feat_sel == 32'd1) begin
                    w_reg_rd = w_feats[63:32];
                end
            end
            vmmio_pkg::OFF_QUEUE_SEL:  w_reg_rd = r_queue_sel;
            vmmio_pkg::OFF_QUEUE_MAX: begin
                w_reg_rd = (r_dev_present && w_qok) ? 32'(QUEUE_MAX) : 32'd0;
            end
            vmmio_pkg::OFF_INT_STATUS: w_reg_rd = r_int_status;
            vmmio_pkg::OFF_STATUS:     w_reg_rd = r_dev_status;
            vmmio_pkg::OFF_CONFIG_GEN: w_reg_rd = r_cfg_gen;
            vmmio_pkg::OFF_QUEUE_NUM:  w_reg_rd = w_qok ? 32'(r_qlen[w_q]) : 32'd0;
            vmmio_pkg::OFF_QUEUE_READY: begin
                w_reg_rd = w_qok ? {31'd0, r_qrdy[w_q]} : 32'd0;
            end
            vmmio_pkg::OFF_DESC_LOW:   w_reg_rd = w_qok ? r_desc[w_q][31:0]  : 32'd0;
            vmmio_pkg::OFF_DESC_HIGH:  w_reg_rd = w_qok ? r_desc[w_q][63:32] : 32'd0;
            vmmio_pkg::OFF_AVAIL_LOW:  w_reg_rd = w_qok ? r_avail[w_q][31:0]  : 32'd0;
            vmmio_pkg::OFF_AVAIL_HIGH: w_reg_rd = w_qok ? r_avail[w_q][63:32] : 32'd0;
            vmmio_pkg::OFF_USED_LOW:   w_reg_rd = w_qok ? r_used[w_q][31:0]  : 32'd0;
            vmmio_pkg::OFF_USED_HIGH:  w_reg_rd = w_qok ? r_used[w_q][63:32] : 32'd0;
            default: w_reg_rd = 32'd0;
        endcase
    end

    always_comb begin
        n_feat_sel     = r_feat_sel;
        n_drv_sel      = r_drv_sel;
        n_drv_feat     = r_drv_feat;
        n_page_size    = r_page_size;
        n_queue_sel    = r_queue_sel;
        n_qlen         = r_qlen;
        n_qrdy         = r_qrdy;
        n_desc         = r_desc;
        n_avail        = r_avail;
        n_used         = r_used;
        n_int_status   = r_int_status;
        n_dev_status   = r_dev_status;
        n_read_data    = 64'd0;
        n_notify_valid = 1'b0;
        n_notify_queue = 1'b0;

        case (i_op)
            vmmio_pkg::OP_READ: begin
                if (w_in_window) begin
                    n_read_data = w_win_data;
                end else if (i_access_size == 4'd4) begin
                    n_read_data = {32'd0, w_reg_rd};
                end
            end
            vmmio_pkg::OP_WRITE: begin
                if (w_reg_access) begin
                    case (i_offset)
                        vmmio_pkg::OFF_DEV_FEAT_SEL: n_feat_sel  = i_write_data;
                        vmmio_pkg::OFF_DRV_FEAT_SEL: n_drv_sel   = i_write_data;
                        vmmio_pkg::OFF_DRV_FEAT: begin
                            if (r_drv_sel != 32'd0) begin
                                n_drv_feat[63:32] = i_write_data;
                            end else begin
                                n_drv_feat[31:0] = i_write_data;
                            end
                        end
                        vmmio_pkg::OFF_PAGE_SIZE:    n_page_size = i_write_data;
                        vmmio_pkg::OFF_INT_ACK: begin
                            n_int_status = r_int_status & ~i_write_data;
                        end
                        vmmio_pkg::OFF_STATUS: begin
                            if (i_write_data == 32'd0) begin
                                n_feat_sel   = 32'd0;
                                n_drv_sel    = 32'd0;
                                n_drv_feat   = 64'd0;
                                n_page_size  = vmmio_pkg::PAGE_SIZE_RESET;
                                n_queue_sel  = 32'd0;
                                n_int_status = 32'd0;
                                n_dev_status = 32'd0;
                                for (int q = 0; q < QUEUE_COUNT; q++) begin
                                    n_qlen[q]  = '0;
                                    n_qrdy[q]  = 1'b0;
                                    n_desc[q]  = 64'd0;
                                    n_avail[q] = 64'd0;
                                    n_used[q]  = 64'd0;
                                end
                            end else begin
                                n_dev_status = i_write_data;
                            end
                        end
                        vmmio_pkg::OFF_QUEUE_SEL:    n_queue_sel = i_write_data;
                        vmmio_pkg::OFF_QUEUE_NOTIFY: begin
                            if (r_dev_present && (i_write_data < 32'(QUEUE_COUNT))) begin
                                n_notify_valid = 1'b1;
                                n_notify_queue = i_write_data[0];
                            end
                        end
                        vmmio_pkg::OFF_QUEUE_NUM: begin
                            if (w_qok) begin
                                n_qlen[w_q] = (i_write_data > 32'(QUEUE_MAX)) ?
                                              QMAX_V : i_write_data[LW-1:0];
                            end
                        end
                        vmmio_pkg::OFF_QUEUE_READY: begin
                            if (w_qok) n_qrdy[w_q] = i_write_data != 32'd0;
                        end
                        vmmio_pkg::OFF_DESC_LOW: begin
                            if (w_qok) n_desc[w_q][31:0] = i_write_data;
                        end
                        vmmio_pkg::OFF_DESC_HIGH: begin
                            if (w_qok) n_desc[w_q][63:32] = i_write_data;
                        end
                        vmmio_pkg::OFF_AVAIL_LOW: begin
                            if (w_qok) n_avail[w_q][31:0] = i_write_data;
                        end
                        vmmio_pkg::OFF_AVAIL_HIGH: begin
                            if (w_qok) n_avail[w_q][63:32] = i_write_data;
                        end
                        vmmio_pkg::OFF_USED_LOW: begin
                            if (w_qok) n_used[w_q][31:0] = i_write_data;
                        end
                        vmmio_pkg::OFF_USED_HIGH: begin
                            if (w_qok) n_used[w_q][63:32] = i_write_data;
                        end
                        default: ;
                    endcase
                end
            end
            vmmio_pkg::OP_RAISE: begin
                n_int_status = r_int_status | i_raise_bits;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_present <= 1'b0;
            r_mac         <= 48'd0;
            r_cfg_gen     <= 32'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                vmmio_pkg::CFG_DEVICE_PRESENT:    r_dev_present <= i_cfg_data[0];
                vmmio_pkg::CFG_MAC_ADDRESS:       r_mac         <= i_cfg_data;
                vmmio_pkg::CFG_CONFIG_GENERATION: r_cfg_gen     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat_sel   <= 32'd0;
            r_drv_sel    <= 32'd0;
            r_drv_feat   <= 64'd0;
            r_page_size  <= vmmio_pkg::PAGE_SIZE_RESET;
            r_queue_sel  <= 32'd0;
            r_int_status <= 32'd0;
            r_dev_status <= 32'd0;
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_qlen[q]  <= '0;
                r_qrdy[q]  <= 1'b0;
                r_desc[q]  <= 64'd0;
                r_avail[q] <= 64'd0;
                r_used[q]  <= 64'd0;
            end
        end else if (w_in_acc) begin
            r_feat_sel   <= n_feat_sel;
            r_drv_sel    <= n_drv_sel;
            r_drv_feat   <= n_drv_feat;
            r_page_size  <= n_page_size;
            r_queue_sel  <= n_queue_sel;
            r_int_status <= n_int_status;
            r_dev_status <= n_dev_status;
            r_qlen       <= n_qlen;
            r_qrdy       <= n_qrdy;
            r_desc       <= n_desc;
            r_avail      <= n_avail;
            r_used       <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_read_data    <= n_read_data;
            r_notify_valid <= n_notify_valid;
            r_notify_queue <= n_notify_queue;
            r_irq_line     <= n_int_status != 32'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_notify_valid = r_notify_valid;
    assign o_notify_queue = r_notify_queue;
    assign o_irq_line     = r_irq_line;

    `VMM_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid,
        "result register not empty after reset")

    `VMM_ASSERT(a_irq_matches, i_clk, i_rst_n,
        o_out_valid |-> (o_irq_line == (r_int_status != 32'd0)),
        "irq line disagrees with interrupt status")

    `VMM_ASSERT(a_notify_present, i_clk, i_rst_n,
        (o_out_valid && o_notify_valid) |-> r_dev_present,
        "notify raised for absent device")

    generate
        for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_qlen_chk
            `VMM_ASSERT(a_qlen_clamped, i_clk, i_rst_n, r_qlen[g] <= QMAX_V,
                "queue length above maximum")
        end
    endgenerate

endmodule
